// ===== src/ggv_pkg.sv =====
// shared types, widths, register codes and arithmetic helpers of the variance filter
package ggv_pkg;

   localparam int SAMPLE_W    = 32;
   localparam int GAIN_W      = 32;
   localparam int VAR_W       = 48;
   localparam int VOL_W       = 24;
   localparam int HALF_W      = 24;
   localparam int SQ_SHIFT    = 16;
   localparam int FRAC_SHIFT  = 31;
   localparam int PART_W      = GAIN_W + HALF_W;
   localparam int WIDE_W      = PART_W + HALF_W;
   localparam int TERM_W      = WIDE_W - FRAC_SHIFT;
   localparam int SUM_W       = TERM_W + 3;
   localparam int SQRT_STAGES = VAR_W / 2;
   localparam int REM_W       = VOL_W + 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 48;

   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_OMEGA       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ARCH        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERSISTENCE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ASYMMETRY   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR       = 3'd5;

   typedef struct packed {
      logic [VAR_W-1:0]  omega_term;
      logic [GAIN_W-1:0] arch_gain;
      logic [GAIN_W-1:0] persistence_gain;
      logic [GAIN_W-1:0] asymmetry_gain;
      logic [VAR_W-1:0]  start_variance;
      logic [VAR_W-1:0]  variance_floor;
   } ggv_cfg_type;

   localparam ggv_cfg_type CFG_RESET = '{
      omega_term:       48'd17592186,
      arch_gain:        32'd171798692,
      persistence_gain: 32'd1932735283,
      asymmetry_gain:   32'd107374182,
      start_variance:   48'd703687441777,
      variance_floor:   48'd175922
   };

   typedef struct packed {
      logic [VAR_W-1:0] variance_out;
      logic             floor_hit;
      logic             saturated;
   } ggv_result_type;

   typedef enum logic [1:0] {
      B_WAIT,
      B_TERM,
      B_SUM
   } ggv_back_state_type;

   // one partial product of a gain and half of a variance word
   function automatic logic [PART_W-1:0] mul_part(input logic [GAIN_W-1:0] gain,
                                                 input logic [HALF_W-1:0] half);
      return PART_W'(gain) * PART_W'(half);
   endfunction

   // joins the two partial products and drops the gain fraction
   function automatic logic [TERM_W-1:0] gain_term(input logic [PART_W-1:0] hi,
                                                  input logic [PART_W-1:0] lo);
      logic [WIDE_W-1:0] wide;
      wide = {hi, {HALF_W{1'b0}}} + WIDE_W'(lo);
      return wide[WIDE_W-1:FRAC_SHIFT];
   endfunction

endpackage

// ===== src/ggv_req_if.sv =====
// return sample channel
interface ggv_req_if;
   import ggv_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] return_sample;

   modport source (output valid, output return_sample, input ready);
   modport sink   (input valid, input return_sample, output ready);
endinterface

// ===== src/ggv_rsp_if.sv =====
// variance result channel
interface ggv_rsp_if;
   import ggv_pkg::*;

   logic             valid;
   logic             ready;
   logic [VAR_W-1:0] variance_out;
   logic [VOL_W-1:0] volatility_out;
   logic             floor_hit;
   logic             saturated;

   modport source (output valid, output variance_out, output volatility_out,
                   output floor_hit, output saturated, input ready);
   modport sink   (input valid, input variance_out, input volatility_out,
                   input floor_hit, input saturated, output ready);
endinterface

// ===== src/ggv_csr_if.sv =====
// register write channel
interface ggv_csr_if;
   import ggv_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] write_data;

   modport source (output valid, output reg_index, output write_data, input ready);
   modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

// ===== src/gjr_garch_variance_filter.sv =====
// top level of the gjr-garch(1,1) conditional variance filter
//
// req_chan takes one signed q1.30 return per beat; rsp_chan gives one beat per
// return: the new q4.44 variance, its truncated square root as q2.22
// volatility, and the floor and saturation flags. csr_chan writes the six
// gain and level registers and is always ready; write them only while the
// block is idle.
// path from an accepted return to its result: four front stages, the queue,
// three back steps and 24 square root stages.
// the back sequencer takes a new return only once it has handed off the last,
// since the beta product, its truncation and the clamped, floored sum form the
// loop into the next previous variance.
// reset: registers take their default values and the first return uses
// start_variance as its previous variance.
// when the receiver stalls, the square root pipeline holds its result, the back
// waits with its sum, the queue fills and the front then drops req ready.
module gjr_garch_variance_filter #(
   parameter int QUEUE_DEPTH = ggv_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ggv_req_if.sink    req_chan,
   ggv_rsp_if.source  rsp_chan,
   ggv_csr_if.sink    csr_chan
);
   import ggv_pkg::*;

   // register file
   ggv_cfg_type cfg_ff, cfg_in;

   // front to queue
   logic             push;
   logic [SUM_W-1:0] push_data;
   logic             q_full;

   // queue to back
   logic             q_not_empty;
   logic [SUM_W-1:0] q_data;
   logic             q_pop;

   // back to square root
   logic             sqrt_en;
   logic             handoff;
   ggv_result_type   result;

   assign csr_chan.ready = 1'b1;

   // writes to an index beyond the list fall through and are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.reg_index)
            CSR_OMEGA:       cfg_in.omega_term       = csr_chan.write_data[VAR_W-1:0];
            CSR_ARCH:        cfg_in.arch_gain        = csr_chan.write_data[GAIN_W-1:0];
            CSR_PERSISTENCE: cfg_in.persistence_gain = csr_chan.write_data[GAIN_W-1:0];
            CSR_ASYMMETRY:   cfg_in.asymmetry_gain   = csr_chan.write_data[GAIN_W-1:0];
            CSR_START:       cfg_in.start_variance   = csr_chan.write_data[VAR_W-1:0];
            CSR_FLOOR:       cfg_in.variance_floor   = csr_chan.write_data[VAR_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // squaring and the alpha and gamma terms, independent of the recurrence
   ggv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cfg       (cfg_ff),
      .q_full    (q_full),
      .push      (push),
      .push_data (push_data)
   );

   // decouples the front from the back
   ggv_queue #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (SUM_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .pop_data  (q_data)
   );

   // recurrence on the previous variance
   ggv_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_not_empty (q_not_empty),
      .q_data      (q_data),
      .q_pop       (q_pop),
      .sqrt_en     (sqrt_en),
      .handoff     (handoff),
      .result      (result)
   );

   // volatility and the output beat
   ggv_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (handoff),
      .in_result (result),
      .en        (sqrt_en),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ===== src/ggv_front.sv =====
// front pipeline: sign split, squaring and the alpha and gamma terms
module ggv_front (
   input  logic                      clock,
   input  logic                      reset,
   ggv_req_if.sink                   req_chan,
   input  ggv_pkg::ggv_cfg_type      cfg,
   input  logic                      q_full,
   output logic                      push,
   output logic [ggv_pkg::SUM_W-1:0] push_data
);
   import ggv_pkg::*;

   logic                en;
   logic [SAMPLE_W-1:0] raw;
   logic [SAMPLE_W-1:0] mag;
   logic [2*SAMPLE_W-1:0] sq_full;

   logic              valid1_ff, valid2_ff, valid3_ff, valid4_ff;
   logic              neg1_ff, neg2_ff;
   logic [VAR_W-1:0]  sq1_ff;
   logic [PART_W-1:0] pa_lo_ff, pa_hi_ff, pg_lo_ff, pg_hi_ff;
   logic [TERM_W-1:0] a3_ff, g3_ff;
   logic [SUM_W-1:0]  x4_ff;

   // whole pipeline holds while the last stage cannot enter the queue
   assign en             = !valid4_ff || !q_full;
   assign req_chan.ready = en;
   assign push           = valid4_ff && !q_full;
   assign push_data      = x4_ff;

   always_comb begin
      raw     = unsigned'(req_chan.return_sample);
      mag     = raw[SAMPLE_W-1] ? (~raw + SAMPLE_W'(1)) : raw;
      sq_full = (2*SAMPLE_W)'(mag) * (2*SAMPLE_W)'(mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else if (en) begin
         valid1_ff <= req_chan.valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
         valid4_ff <= valid3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg1_ff  <= raw[SAMPLE_W-1];
         sq1_ff   <= sq_full[SQ_SHIFT +: VAR_W];
         neg2_ff  <= neg1_ff;
         pa_lo_ff <= mul_part(cfg.arch_gain, sq1_ff[HALF_W-1:0]);
         pa_hi_ff <= mul_part(cfg.arch_gain, sq1_ff[VAR_W-1:HALF_W]);
         pg_lo_ff <= mul_part(cfg.asymmetry_gain, sq1_ff[HALF_W-1:0]);
         pg_hi_ff <= mul_part(cfg.asymmetry_gain, sq1_ff[VAR_W-1:HALF_W]);
         a3_ff    <= gain_term(pa_hi_ff, pa_lo_ff);
         g3_ff    <= neg2_ff ? gain_term(pg_hi_ff, pg_lo_ff) : '0;
         x4_ff    <= SUM_W'(cfg.omega_term) + SUM_W'(a3_ff) + SUM_W'(g3_ff);
      end
   end

endmodule

// ===== src/ggv_queue.sv =====
// small first-in first-out queue between front and back
module ggv_queue #(
   parameter int DEPTH = ggv_pkg::QUEUE_DEPTH_DEF,
   parameter int WIDTH = ggv_pkg::SUM_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue popped while empty");

endmodule

// ===== src/ggv_back.sv =====
// back sequencer: beta product on the previous variance, sum, clamp and floor
module ggv_back (
   input  logic                      clock,
   input  logic                      reset,
   input  ggv_pkg::ggv_cfg_type      cfg,
   input  logic                      q_not_empty,
   input  logic [ggv_pkg::SUM_W-1:0] q_data,
   output logic                      q_pop,
   input  logic                      sqrt_en,
   output logic                      handoff,
   output ggv_pkg::ggv_result_type   result
);
   import ggv_pkg::*;

   ggv_back_state_type state_ff, state_in;

   logic [SUM_W-1:0]  x_ff;
   logic [PART_W-1:0] pb_lo_ff, pb_hi_ff;
   logic [TERM_W-1:0] beta_t_ff;
   logic [VAR_W-1:0]  prior_ff;
   logic              primed_ff;

   logic [VAR_W-1:0]  prev;
   logic [SUM_W-1:0]  sum;
   logic              sat;
   logic [VAR_W-1:0]  clamped;
   logic              fl;

   assign prev = primed_ff ? prior_ff : cfg.start_variance;

   always_comb begin
      sum     = x_ff + SUM_W'(beta_t_ff);
      sat     = |sum[SUM_W-1:VAR_W];
      clamped = sat ? '1 : sum[VAR_W-1:0];
      fl      = clamped < cfg.variance_floor;
      result.variance_out = fl ? cfg.variance_floor : clamped;
      result.floor_hit    = fl;
      result.saturated    = sat;
   end

   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      handoff  = 1'b0;
      case (state_ff)
         B_WAIT: begin
            if (q_not_empty) begin
               q_pop    = 1'b1;
               state_in = B_TERM;
            end
         end
         B_TERM: begin
            state_in = B_SUM;
         end
         B_SUM: begin
            if (sqrt_en) begin
               handoff  = 1'b1;
               state_in = B_WAIT;
            end
         end
         default: begin
            state_in = B_WAIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_WAIT;
         primed_ff <= 1'b0;
         prior_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (handoff) begin
            primed_ff <= 1'b1;
            prior_ff  <= result.variance_out;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         x_ff     <= q_data;
         pb_lo_ff <= mul_part(cfg.persistence_gain, prev[HALF_W-1:0]);
         pb_hi_ff <= mul_part(cfg.persistence_gain, prev[VAR_W-1:HALF_W]);
      end
      if (state_ff == B_TERM) begin
         beta_t_ff <= gain_term(pb_hi_ff, pb_lo_ff);
      end
   end

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      handoff |-> !(result.floor_hit && result.saturated))
      else $error("floor and saturation flagged together");

   a_above_floor: assert property (@(posedge clock) disable iff (reset)
      handoff |-> (result.variance_out >= cfg.variance_floor))
      else $error("variance below floor");

   a_prior_updated: assert property (@(posedge clock) disable iff (reset)
      handoff |=> (primed_ff && (prior_ff == $past(result.variance_out))))
      else $error("previous variance not taken from result");

endmodule

// ===== src/ggv_sqrt.sv =====
// pipelined integer square root, two radicand bits a stage, its last stage driving the output
module ggv_sqrt (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  ggv_pkg::ggv_result_type in_result,
   output logic                    en,
   ggv_rsp_if.source               rsp_chan
);
   import ggv_pkg::*;

   localparam int LAST = SQRT_STAGES - 1;

   logic           valid_ff  [SQRT_STAGES];
   logic [REM_W-1:0] rem_ff  [SQRT_STAGES];
   logic [VOL_W-1:0] root_ff [SQRT_STAGES];
   ggv_result_type res_ff    [SQRT_STAGES];

   logic           valid_prev [SQRT_STAGES];
   logic [REM_W-1:0] rem_prev [SQRT_STAGES];
   logic [VOL_W-1:0] root_prev [SQRT_STAGES];
   ggv_result_type res_prev   [SQRT_STAGES];

   // every stage holds while the finished result waits
   assign en = !valid_ff[LAST] || rsp_chan.ready;

   assign rsp_chan.valid          = valid_ff[LAST];
   assign rsp_chan.variance_out   = res_ff[LAST].variance_out;
   assign rsp_chan.volatility_out = root_ff[LAST];
   assign rsp_chan.floor_hit      = res_ff[LAST].floor_hit;
   assign rsp_chan.saturated      = res_ff[LAST].saturated;

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
      logic [REM_W+1:0] rem_ext;
      logic [REM_W+1:0] trial;
      logic             ge;

      if (k == 0) begin : g_head
         assign valid_prev[k] = in_valid;
         assign rem_prev[k]   = '0;
         assign root_prev[k]  = '0;
         assign res_prev[k]   = in_result;
      end else begin : g_body
         assign valid_prev[k] = valid_ff[k-1];
         assign rem_prev[k]   = rem_ff[k-1];
         assign root_prev[k]  = root_ff[k-1];
         assign res_prev[k]   = res_ff[k-1];
      end

      always_comb begin
         rem_ext = {rem_prev[k], res_prev[k].variance_out[VAR_W-1-2*k -: 2]};
         trial   = (REM_W+2)'({root_prev[k], 2'b01});
         ge      = rem_ext >= trial;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? REM_W'(rem_ext - trial) : REM_W'(rem_ext);
            root_ff[k] <= {root_prev[k][VOL_W-2:0], ge};
            res_ff[k]  <= res_prev[k];
         end
      end
   end

   a_root_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> ((VAR_W'(root_ff[LAST]) * VAR_W'(root_ff[LAST]))
                          <= res_ff[LAST].variance_out))
      else $error("volatility above square root of variance");

endmodule
